>>> hdl/rrjs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrjs_pkg
// shared types, constants and helpers of the round robin job scheduler
// ----------------------------------------------------------------------------
package rrjs_pkg;

	localparam int TIME_W      = 24;
	localparam int SLOT_W      = 4;
	localparam int BURST_W     = 16;
	localparam int SLICE_W     = 8;
	localparam int MAX_JOBS_DEF = 16;

	localparam logic [TIME_W-1:0]  TIME_MAX      = '1;
	localparam logic [SLICE_W-1:0] SLICE_MAX     = '1;
	localparam logic [SLICE_W-1:0] QUANTUM_RESET = 8'd4;

	// item codes
	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0]  seg_start;
		logic [SLOT_W-1:0]  seg_job;
		logic [SLICE_W-1:0] seg_length;
		logic               finished;
		logic [TIME_W-1:0]  turnaround;
		logic [TIME_W-1:0]  waiting;
		logic [TIME_W-1:0]  response;
	} result_t;

	// job table write on arrival
	typedef struct packed {
		logic               we;
		logic [SLOT_W-1:0]  slot;
		logic [TIME_W-1:0]  arrival;
		logic [BURST_W-1:0] burst;
	} arrival_wr_t;

	// job table read port, limit is arrival plus burst
	typedef struct packed {
		logic [TIME_W-1:0]  arrival;
		logic [TIME_W:0]    limit;
		logic [BURST_W-1:0] left;
		logic [TIME_W-1:0]  first_start;
	} job_rd_t;

	// difference clamped at zero
	function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W:0] a,
		input logic [TIME_W:0] b);
		logic [TIME_W:0] d;
		d = a - b;
		return (a > b) ? d[TIME_W-1:0] : '0;
	endfunction

endpackage

>>> hdl/rrjs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrjs_fifo
// circular job queue with registered head word, pop applied before push
// ----------------------------------------------------------------------------
module rrjs_fifo import rrjs_pkg::*; #(
	parameter int DEPTH = MAX_JOBS_DEF,
	parameter int W     = SLOT_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [W-1:0]                 push_data,
	input  logic                         pop,
	output logic [W-1:0]                 head_data,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);
	localparam int SW = AW + 1;

	logic [W-1:0]  mem [DEPTH];
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [W-1:0]  rd_q;

	logic          pop_ok;
	logic          push_ok;
	logic [AW-1:0] head_pop;
	logic [CW-1:0] count_pop;
	logic [SW-1:0] tail_sum;
	logic [AW-1:0] tail;

	always_comb begin
		pop_ok    = pop && (count_q != '0);
		count_pop = count_q - CW'(pop_ok);
		if (pop_ok) begin
			head_pop = (head_q == AW'(DEPTH-1)) ? '0 : head_q + 1'b1;
		end else begin
			head_pop = head_q;
		end
		push_ok  = push && (count_pop < CW'(DEPTH));
		tail_sum = SW'(head_pop) + SW'(count_pop);
		if (tail_sum >= SW'(DEPTH)) begin
			tail_sum = tail_sum - SW'(DEPTH);
		end
		tail = tail_sum[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_pop;
			count_q <= count_pop + CW'(push_ok);
		end
	end

	// storage and next head word, forwarded when a push lands on an empty queue
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[tail] <= push_data;
		end
		if (push_ok && (count_pop == '0)) begin
			rd_q <= push_data;
		end else begin
			rd_q <= mem[head_pop];
		end
	end

	assign head_data = rd_q;
	assign count     = count_q;

endmodule

>>> hdl/rrjs_job_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrjs_job_table
// per slot arrival, limit, remaining time and first start
// ----------------------------------------------------------------------------
module rrjs_job_table import rrjs_pkg::*; #(
	parameter int NUM_SLOTS = MAX_JOBS_DEF
) (
	input  logic                           clk,
	input  arrival_wr_t                    arr_wr,
	input  logic                           left_we,
	input  logic [$clog2(NUM_SLOTS)-1:0]   left_idx,
	input  logic [BURST_W-1:0]             left_val,
	input  logic                           first_we,
	input  logic [TIME_W-1:0]              first_val,
	input  logic [$clog2(NUM_SLOTS)-1:0]   rd_idx,
	output job_rd_t                        rd
);

	localparam int IW = $clog2(NUM_SLOTS);

	logic [TIME_W-1:0]  arrival_q [NUM_SLOTS];
	logic [TIME_W:0]    limit_q   [NUM_SLOTS];
	logic [BURST_W-1:0] left_q    [NUM_SLOTS];
	logic [TIME_W-1:0]  first_q   [NUM_SLOTS];

	logic [IW-1:0] wr_idx;

	assign wr_idx = arr_wr.slot[IW-1:0];

	always_ff @(posedge clk) begin
		if (arr_wr.we) begin
			arrival_q[wr_idx] <= arr_wr.arrival;
			limit_q[wr_idx]   <= {1'b0, arr_wr.arrival} + (TIME_W+1)'(arr_wr.burst);
			left_q[wr_idx]    <= arr_wr.burst;
		end
		if (left_we) begin
			left_q[left_idx] <= left_val;
		end
		if (first_we) begin
			first_q[rd_idx] <= first_val;
		end
	end

	always_comb begin
		rd.arrival     = arrival_q[rd_idx];
		rd.limit       = limit_q[rd_idx];
		rd.left        = left_q[rd_idx];
		rd.first_start = first_q[rd_idx];
	end

endmodule

>>> hdl/rrjs_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrjs_out_buf
// result register with one skid entry
// ----------------------------------------------------------------------------
module rrjs_out_buf import rrjs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_valid,
	input  result_t res,
	output logic    in_stall,
	output logic    out_valid,
	output result_t out_res,
	input  logic    out_stall
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    out_fire;

	assign out_fire = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_fire) begin
			out_valid_q <= res_valid;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || out_fire) begin
			out_q <= res;
		end else begin
			skid_q <= res;
		end
	end

	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

>>> hdl/round_robin_job_scheduler_unit.sv
`timescale 1ns / 1ps
// a tick that ends a segment registers its word in the result register or the skid entry
// throughput: one word per cycle, arrival or tick; the result register plus a skid
//   entry let input flow on until two results wait stalled
// reset: arst_n clears both queues, run state, slice count and time, quantum goes to 4
// job tables are undefined until a job arrives in that slot; no clearing pass
// ----------------------------------------------------------------------------
// round_robin_job_scheduler_unit
// single processor round robin scheduler with a configurable time slice
// ----------------------------------------------------------------------------
module round_robin_job_scheduler_unit import rrjs_pkg::*; #(
	parameter int MAX_JOBS = MAX_JOBS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// quantum write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [SLICE_W-1:0]  quantum,
	// item channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                func,
	input  logic [SLOT_W-1:0]   job_slot,
	input  logic [BURST_W-1:0]  job_burst,
	// run segment channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [TIME_W-1:0]   segment_start,
	output logic [SLOT_W-1:0]   segment_job,
	output logic [SLICE_W-1:0]  segment_length,
	output logic                job_finished,
	output logic [TIME_W-1:0]   turnaround_time,
	output logic [TIME_W-1:0]   waiting_time,
	output logic [TIME_W-1:0]   response_time
);

	// table slots never exceed what the slot field can name
	localparam int NUM_SLOTS = (MAX_JOBS < (2**SLOT_W)) ? MAX_JOBS : (2**SLOT_W);
	localparam int IW        = $clog2(NUM_SLOTS);
	localparam int QCW       = $clog2(MAX_JOBS+1);

	// run state
	logic [SLICE_W-1:0] quantum_q;
	logic [TIME_W-1:0]  now_q;
	logic [SLICE_W-1:0] slice_q;
	logic [IW-1:0]      run_q;
	logic               busy_q;

	// item decode
	logic accept;
	logic is_arrive;
	logic is_tick;
	logic arrive_ok;

	// queue interface
	logic [IW-1:0]  fresh_head;
	logic [IW-1:0]  pre_head;
	logic [QCW-1:0] fresh_cnt;
	logic [QCW-1:0] pre_cnt;
	logic           pop_fresh;
	logic           pop_pre;
	logic           push_pre;

	// tick datapath
	arrival_wr_t        arr_wr;
	job_rd_t            rd;
	logic [IW-1:0]      cur;
	logic               run;
	logic [TIME_W-1:0]  now_inc;
	logic [SLICE_W-1:0] slice_inc;
	logic [BURST_W-1:0] left_dec;
	logic               done;
	logic               expired;
	logic [TIME_W-1:0]  first_eff;
	logic               res_valid;
	result_t            res;
	result_t            out_res;

	assign cfg_ready = 1'b1;

	assign accept    = in_valid && !in_stall;
	assign is_arrive = accept && (func == FUNC_ARRIVE);
	assign is_tick   = accept && (func == FUNC_TICK);
	// slot out of range or fresh queue full drops the arrival
	assign arrive_ok = is_arrive && (int'(job_slot) < MAX_JOBS)
		&& (fresh_cnt != QCW'(MAX_JOBS));

	always_comb begin
		arr_wr.we      = arrive_ok;
		arr_wr.slot    = job_slot;
		arr_wr.arrival = now_q;
		arr_wr.burst   = job_burst;
	end

	// idle processor: fresh jobs first, then preempted ones
	assign pop_fresh = is_tick && !busy_q && (fresh_cnt != '0);
	assign pop_pre   = is_tick && !busy_q && (fresh_cnt == '0) && (pre_cnt != '0);
	assign run       = is_tick && (busy_q || pop_fresh || pop_pre);

	always_comb begin
		if (busy_q) begin
			cur = run_q;
		end else if (pop_fresh) begin
			cur = fresh_head;
		end else begin
			cur = pre_head;
		end
	end

	always_comb begin
		now_inc   = (now_q == TIME_MAX) ? now_q : now_q + 1'b1;
		slice_inc = (slice_q == SLICE_MAX) ? slice_q : slice_q + 1'b1;
		left_dec  = (rd.left != '0) ? rd.left - 1'b1 : '0;
		done      = (left_dec == '0);
		expired   = (slice_inc >= quantum_q);
		// first start is written this very tick when a fresh job is taken
		first_eff = pop_fresh ? now_q : rd.first_start;
		res_valid = run && (done || expired);
		push_pre  = run && !done && expired;
	end

	always_comb begin
		res.seg_start  = sat_sub({1'b0, now_inc}, (TIME_W+1)'(slice_inc));
		res.seg_job    = SLOT_W'(cur);
		res.seg_length = slice_inc;
		res.finished   = done;
		res.turnaround = '0;
		res.waiting    = '0;
		res.response   = '0;
		if (done) begin
			res.turnaround = sat_sub({1'b0, now_inc}, {1'b0, rd.arrival});
			// turnaround minus burst equals now minus arrival plus burst, clamped
			res.waiting    = sat_sub({1'b0, now_inc}, rd.limit);
			res.response   = sat_sub({1'b0, first_eff}, {1'b0, rd.arrival});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
			now_q     <= '0;
			slice_q   <= '0;
			run_q     <= '0;
			busy_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				quantum_q <= quantum;
			end
			if (is_tick) begin
				now_q <= now_inc;
			end
			if (run) begin
				run_q <= cur;
				if (done || expired) begin
					busy_q  <= 1'b0;
					slice_q <= '0;
				end else begin
					busy_q  <= 1'b1;
					slice_q <= slice_inc;
				end
			end
		end
	end

	rrjs_fifo #(
		.DEPTH (MAX_JOBS),
		.W     (IW)
	) u_fresh_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (arrive_ok),
		.push_data (job_slot[IW-1:0]),
		.pop       (pop_fresh),
		.head_data (fresh_head),
		.count     (fresh_cnt)
	);

	// a preempted job that finds this queue full is lost, segment still reported
	rrjs_fifo #(
		.DEPTH (MAX_JOBS),
		.W     (IW)
	) u_pre_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_pre),
		.push_data (cur),
		.pop       (pop_pre),
		.head_data (pre_head),
		.count     (pre_cnt)
	);

	rrjs_job_table #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_job_table (
		.clk       (clk),
		.arr_wr    (arr_wr),
		.left_we   (run),
		.left_idx  (cur),
		.left_val  (left_dec),
		.first_we  (pop_fresh),
		.first_val (now_q),
		.rd_idx    (cur),
		.rd        (rd)
	);

	rrjs_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.out_stall (out_stall)
	);

	assign segment_start   = out_res.seg_start;
	assign segment_job     = out_res.seg_job;
	assign segment_length  = out_res.seg_length;
	assign job_finished    = out_res.finished;
	assign turnaround_time = out_res.turnaround;
	assign waiting_time    = out_res.waiting;
	assign response_time   = out_res.response;

endmodule

>>> tb/tb_round_robin_job_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_job_scheduler_unit
// self-checking bench: job arrivals and ticks go in, run segment words are
// checked against an in-bench scheduler model, with random gaps and stalls
// ----------------------------------------------------------------------------
module tb_round_robin_job_scheduler_unit;
	import rrjs_pkg::*;

	localparam int MAX_JOBS       = MAX_JOBS_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 4;

	// every input starts at a known value
	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cfg_valid  = 1'b0;
	logic               cfg_ready;
	logic [SLICE_W-1:0] quantum    = '0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic               func       = FUNC_ARRIVE;
	logic [SLOT_W-1:0]  job_slot   = '0;
	logic [BURST_W-1:0] job_burst  = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic [TIME_W-1:0]  segment_start;
	logic [SLOT_W-1:0]  segment_job;
	logic [SLICE_W-1:0] segment_length;
	logic               job_finished;
	logic [TIME_W-1:0]  turnaround_time;
	logic [TIME_W-1:0]  waiting_time;
	logic [TIME_W-1:0]  response_time;

	// scheduler model state
	logic [TIME_W-1:0]  arrival_tab [MAX_JOBS];
	logic [BURST_W-1:0] burst_tab   [MAX_JOBS];
	logic [BURST_W-1:0] left_tab    [MAX_JOBS];
	logic [TIME_W-1:0]  start_tab   [MAX_JOBS];
	logic [SLOT_W-1:0]  fresh_jobs[$];
	logic [SLOT_W-1:0]  preempted_jobs[$];
	logic [SLOT_W-1:0]  run_slot;
	bit                 cpu_busy;
	int unsigned        slice_count;
	int unsigned        clock_now;
	logic [SLICE_W-1:0] slice_limit;

	// run segments still due from the block, oldest first
	result_t            segments_due[$];
	result_t            seg_want;

	int                 fail_count = 0;
	int                 idle_cycles = 0;
	bit                 quiet = 1'b0;     // no gaps or stalls on either side
	bit                 hold_req = 1'b0;  // ask the receiver for a long hold-off

	round_robin_job_scheduler_unit #(
		.MAX_JOBS(MAX_JOBS)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.quantum        (quantum),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.job_slot       (job_slot),
		.job_burst      (job_burst),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.segment_start  (segment_start),
		.segment_job    (segment_job),
		.segment_length (segment_length),
		.job_finished   (job_finished),
		.turnaround_time(turnaround_time),
		.waiting_time   (waiting_time),
		.response_time  (response_time)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// difference that never goes below zero
	function automatic logic [TIME_W-1:0] clamp_diff(input int unsigned a, input int unsigned b);
		return (a > b) ? TIME_W'(a - b) : '0;
	endfunction

	// one item through the scheduler model, returns 1 when a segment ends
	function automatic bit schedule_item(input logic f, input logic [SLOT_W-1:0] s,
		input logic [BURST_W-1:0] b, output result_t seg);
		logic [TIME_W-1:0] turn;
		seg = '0;
		if (f == FUNC_ARRIVE) begin
			// a slot out of range or a full fresh queue drops the arrival entirely
			if ((int'(s) >= MAX_JOBS) || (fresh_jobs.size() >= MAX_JOBS))
				return 1'b0;
			arrival_tab[s] = TIME_W'(clock_now);
			burst_tab[s]   = b;
			left_tab[s]    = b;
			fresh_jobs = {fresh_jobs, s};
			return 1'b0;
		end
		// idle processor: fresh jobs win over preempted ones
		if (!cpu_busy) begin
			if (fresh_jobs.size() > 0) begin
				run_slot = fresh_jobs.pop_front();
				start_tab[run_slot] = TIME_W'(clock_now);
				cpu_busy = 1'b1;
			end else if (preempted_jobs.size() > 0) begin
				run_slot = preempted_jobs.pop_front();
				cpu_busy = 1'b1;
			end
		end
		if (clock_now < TIME_MAX)
			clock_now++;
		if (!cpu_busy)
			return 1'b0;
		if (slice_count < SLICE_MAX)
			slice_count++;
		// zero burst still takes one tick of running
		if (left_tab[run_slot] > 0)
			left_tab[run_slot]--;
		if (left_tab[run_slot] == 0) begin
			turn = clamp_diff(clock_now, arrival_tab[run_slot]);
			seg.seg_start  = clamp_diff(clock_now, slice_count);
			seg.seg_job    = run_slot;
			seg.seg_length = SLICE_W'(slice_count);
			seg.finished   = 1'b1;
			seg.turnaround = turn;
			seg.waiting    = clamp_diff(turn, burst_tab[run_slot]);
			seg.response   = clamp_diff(start_tab[run_slot], arrival_tab[run_slot]);
			cpu_busy = 1'b0;
			slice_count = 0;
			return 1'b1;
		end
		if (slice_count >= slice_limit) begin
			seg.seg_start  = clamp_diff(clock_now, slice_count);
			seg.seg_job    = run_slot;
			seg.seg_length = SLICE_W'(slice_count);
			seg.finished   = 1'b0;
			// full preempted queue loses the job, the segment still shows
			if (preempted_jobs.size() < MAX_JOBS)
				preempted_jobs = {preempted_jobs, run_slot};
			cpu_busy = 1'b0;
			slice_count = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// offer one word, wait for it to be taken, then update the model
	task automatic send_item(input logic f, input logic [SLOT_W-1:0] s,
		input logic [BURST_W-1:0] b);
		result_t seg;
		while (!quiet && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		func      <= f;
		job_slot  <= s;
		job_burst <= b;
		do @(posedge clk); while (in_stall);
		if (schedule_item(f, s, b, seg))
			segments_due = {segments_due, seg};
	endtask

	// stop offering, let every due segment arrive, then let the pipe settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (segments_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// quantum write, only while nothing is in flight
	task automatic write_quantum(input logic [SLICE_W-1:0] q);
		@(posedge clk);
		cfg_valid <= 1'b1;
		quantum   <= q;
		do @(posedge clk); while (!cfg_ready);
		slice_limit = q;
		cfg_valid <= 1'b0;
	endtask

	// mostly short jobs, a few long ones, now and then any burst at all
	function automatic logic [BURST_W-1:0] pick_burst();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return BURST_W'($urandom_range(1));
		if (r < 70)
			return BURST_W'($urandom_range(12, 1));
		if (r < 92)
			return BURST_W'($urandom_range(300, 13));
		return BURST_W'($urandom_range(65535));
	endfunction

	// reset quantum, idle tick, plain round robin, zero burst, top slot
	task automatic test_reset_defaults();
		send_item(FUNC_TICK, '1, '1);
		send_item(FUNC_ARRIVE, 4'd0, 16'd6);
		send_item(FUNC_ARRIVE, 4'd15, 16'd2);
		send_item(FUNC_ARRIVE, 4'd5, 16'd0);
		repeat (10) send_item(FUNC_TICK, '0, '0);
		wait_idle();
	endtask

	// widest and narrowest slices, quantum cut below a running slice,
	// a slot arriving again while it waits preempted
	task automatic test_quantum_extremes();
		write_quantum(8'd255);
		send_item(FUNC_ARRIVE, 4'd3, 16'hFFFF);
		repeat (3) send_item(FUNC_TICK, '0, '0);
		wait_idle();
		write_quantum(8'd1);
		send_item(FUNC_TICK, '0, '0);
		wait_idle();
		write_quantum(8'd0);
		send_item(FUNC_ARRIVE, 4'd9, 16'd5);
		send_item(FUNC_ARRIVE, 4'd3, 16'd1);
		repeat (5) send_item(FUNC_TICK, '0, '0);
		wait_idle();
	endtask

	// fill the fresh queue past its depth, then the preempted queue
	task automatic test_queue_limits();
		write_quantum(8'd1);
		for (int i = 0; i <= MAX_JOBS; i++)
			send_item(FUNC_ARRIVE, SLOT_W'(i), 16'd3);
		repeat (MAX_JOBS) send_item(FUNC_TICK, '0, '0);
		send_item(FUNC_ARRIVE, 4'd7, 16'd2);
		send_item(FUNC_TICK, '0, '0);
		wait_idle();
	endtask

	// receiver holds off for a long stretch while ticks keep coming
	task automatic test_backpressure();
		write_quantum(8'd2);
		for (int i = 0; i < 4; i++)
			send_item(FUNC_ARRIVE, SLOT_W'(i + 10), 16'd30);
		hold_req = 1'b1;
		repeat (80) send_item(FUNC_TICK, '0, '0);
		wait_idle();
	endtask

	// random arrivals and ticks under a series of quanta
	task automatic test_random_mix();
		logic [SLICE_W-1:0] phase_q [8];
		int arrive_pct;
		phase_q = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd255, 8'd0, 8'd0, 8'd0};
		phase_q[6] = SLICE_W'($urandom_range(255));
		phase_q[7] = SLICE_W'($urandom_range(16, 1));
		for (int p = 0; p < 8; p++) begin
			write_quantum(phase_q[p]);
			arrive_pct = $urandom_range(30, 8);
			// one phase runs flat out on both sides
			quiet = (p == 3);
			for (int i = 0; i < 180; i++) begin
				if ($urandom_range(99) < arrive_pct)
					send_item(FUNC_ARRIVE, SLOT_W'($urandom_range(15)), pick_burst());
				else
					send_item(FUNC_TICK, SLOT_W'($urandom), BURST_W'($urandom));
			end
			wait_idle();
			quiet = 1'b0;
		end
	endtask

	// receiver: random stalls, or a counted hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 32);
			end
		end
	end

	// compare each taken segment word with the oldest one due
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (segments_due.size() == 0) begin
				$error("segment_job: expected no word, actual %0d", segment_job);
				fail_count++;
			end else begin
				seg_want = segments_due.pop_front();
				if (segment_start !== seg_want.seg_start) begin
					$error("segment_start: expected %0d, actual %0d",
						seg_want.seg_start, segment_start);
					fail_count++;
				end
				if (segment_job !== seg_want.seg_job) begin
					$error("segment_job: expected %0d, actual %0d",
						seg_want.seg_job, segment_job);
					fail_count++;
				end
				if (segment_length !== seg_want.seg_length) begin
					$error("segment_length: expected %0d, actual %0d",
						seg_want.seg_length, segment_length);
					fail_count++;
				end
				if (job_finished !== seg_want.finished) begin
					$error("job_finished: expected %0d, actual %0d",
						seg_want.finished, job_finished);
					fail_count++;
				end
				if (turnaround_time !== seg_want.turnaround) begin
					$error("turnaround_time: expected %0d, actual %0d",
						seg_want.turnaround, turnaround_time);
					fail_count++;
				end
				if (waiting_time !== seg_want.waiting) begin
					$error("waiting_time: expected %0d, actual %0d",
						seg_want.waiting, waiting_time);
					fail_count++;
				end
				if (response_time !== seg_want.response) begin
					$error("response_time: expected %0d, actual %0d",
						seg_want.response, response_time);
					fail_count++;
				end
			end
		end
	end

	// watchdog: too long with no word taken on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		// model in its reset state
		fresh_jobs.delete();
		preempted_jobs.delete();
		run_slot    = '0;
		cpu_busy    = 1'b0;
		slice_count = 0;
		clock_now   = 0;
		slice_limit = QUANTUM_RESET;
		for (int i = 0; i < MAX_JOBS; i++) begin
			arrival_tab[i] = '0;
			burst_tab[i]   = '0;
			left_tab[i]    = '0;
			start_tab[i]   = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_quantum_extremes();
		test_queue_limits();
		test_backpressure();
		test_random_mix();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
hdl/rrjs_pkg.sv
hdl/rrjs_fifo.sv
hdl/rrjs_job_table.sv
hdl/rrjs_out_buf.sv
hdl/round_robin_job_scheduler_unit.sv
tb/tb_round_robin_job_scheduler_unit.sv
